// File: rtl/core/qte_pkg.sv
// Shared types, widths and the arctangent table for the quaternion to Euler angle block.
// Used by qte_ser_mul, qte_cordic and quaternion_to_euler_angles. No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

  // Component width. All arithmetic widths are derived from this value.
  localparam int unsigned QuatBits = 16;
  // Width of one product after the fraction shift.
  localparam int unsigned PW = QuatBits + 2;
  // Width of a rotation-matrix term.
  localparam int unsigned RW = QuatBits + 3;
  // Shift that scales a matrix term to 32 fraction bits.
  localparam int unsigned ScaleSh = 32 - (QuatBits - 1);
  // Width of the CORDIC vector registers.
  localparam int unsigned XW = RW + ScaleSh + 2;
  // Width of the angle accumulator, which counts 1/256 centidegree.
  localparam int unsigned ZW = 25;
  // Width of the bit counter of the serial multipliers.
  localparam int unsigned MulCntW = $clog2(QuatBits);
  // Number of product lanes.
  localparam int unsigned NumProd = 9;

  localparam int HalfTurnCdeg = 18000;
  localparam logic signed [RW-1:0] QOne = RW'(1) << (QuatBits - 1);

  typedef struct packed {
    logic        [31:0]         frame_number;
    logic signed [QuatBits-1:0] quat_x;
    logic signed [QuatBits-1:0] quat_y;
    logic signed [QuatBits-1:0] quat_z;
    logic signed [QuatBits-1:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_cdeg;
    logic signed [15:0] pitch_cdeg;
    logic               gimbal_lock;
  } out_item_t;

  // Control of the serial multiplier lanes.
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } mul_ctrl_t;

  // Control of the CORDIC units.
  typedef struct packed {
    logic start;
  } cordic_ctrl_t;

  // atan(2^-i) in 1/256 centidegree, rounded to the nearest unit.
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(1152000);
      5'd1:    v = ZW'(680065);
      5'd2:    v = ZW'(359328);
      5'd3:    v = ZW'(182400);
      5'd4:    v = ZW'(91554);
      5'd5:    v = ZW'(45822);
      5'd6:    v = ZW'(22916);
      5'd7:    v = ZW'(11459);
      5'd8:    v = ZW'(5730);
      5'd9:    v = ZW'(2865);
      5'd10:   v = ZW'(1432);
      5'd11:   v = ZW'(716);
      5'd12:   v = ZW'(358);
      5'd13:   v = ZW'(179);
      5'd14:   v = ZW'(90);
      5'd15:   v = ZW'(45);
      5'd16:   v = ZW'(22);
      5'd17:   v = ZW'(11);
      5'd18:   v = ZW'(6);
      5'd19:   v = ZW'(3);
      5'd20:   v = ZW'(1);
      5'd21:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/qte_ser_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle while step is set, result shifted by QuatBits-1.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_ser_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qte_pkg::mul_ctrl_t                  ctrl_i,
  input  logic signed [qte_pkg::QuatBits-1:0] a_i,
  input  logic signed [qte_pkg::QuatBits-1:0] b_i,
  output logic signed [qte_pkg::PW-1:0]       prod_o
);

  localparam int unsigned Q = qte_pkg::QuatBits;

  logic signed [Q-1:0] a_q;
  logic        [Q-1:0] b_q;
  logic signed [Q:0]   hi_q, hi_d;
  logic        [Q-1:0] lo_q, lo_d;
  logic signed [Q+1:0] addend, sum;

  // Add the multiplicand for the current bit; the sign bit carries negative weight.
  always_comb begin
    addend = '0;
    if (b_q[0]) begin
      addend = ctrl_i.last ? -((Q+2)'(a_q)) : (Q+2)'(a_q);
    end
    sum  = (Q+2)'(hi_q) + addend;
    hi_d = sum[Q+1:1];
    lo_d = {sum[0], lo_q[Q-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctrl_i.load) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctrl_i.step) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  // Operand registers; the multiplier shifts out one bit per step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (ctrl_i.step) begin
      b_q <= {1'b0, b_q[Q-1:1]};
    end
  end

  // Product shifted right by Q-1, rounding toward minus infinity.
  assign prod_o = {hi_q, lo_q[Q-1]};

endmodule

// File: rtl/core/qte_cordic.sv
// Iterative vectoring CORDIC giving atan2(y, x) in saturated centidegrees, one step per cycle.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qte_pkg::cordic_ctrl_t         ctrl_i,
  input  logic signed [qte_pkg::RW-1:0] y_i,
  input  logic signed [qte_pkg::RW-1:0] x_i,
  output logic                          done_o,
  output logic signed [15:0]            angle_o
);

  localparam int unsigned XW = qte_pkg::XW;
  localparam int unsigned ZW = qte_pkg::ZW;
  localparam int unsigned IW = $clog2(STEPS);
  localparam logic signed [ZW-1:0] HalfTurn = ZW'(qte_pkg::HalfTurnCdeg * 256);

  logic                 busy_q, done_q, zero_q;
  logic [IW-1:0]        i_q;
  logic signed [XW-1:0] x_q, y_q, xs, ys, dx, dy;
  logic signed [ZW-1:0] z_q, at;
  logic signed [ZW:0]   zr, rs;

  // Scale the arguments to 32 fraction bits.
  assign xs = XW'(x_i) <<< qte_pkg::ScaleSh;
  assign ys = XW'(y_i) <<< qte_pkg::ScaleSh;

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = qte_pkg::atan_tab(5'(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == IW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Vector registers: half-turn pre-rotation on load if x < 0, then one micro-rotation a cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (xs < 0) begin
        z_q <= (ys >= 0) ? HalfTurn : -HalfTurn;
        x_q <= -xs;
        y_q <= -ys;
      end else begin
        z_q <= '0;
        x_q <= xs;
        y_q <= ys;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  // Round to centidegrees and saturate to a half turn; a zero vector gives zero.
  always_comb begin
    zr = (ZW+1)'(z_q) + (ZW+1)'(128);
    rs = zr >>> 8;
    if (zero_q) begin
      angle_o = '0;
    end else if (rs > qte_pkg::HalfTurnCdeg) begin
      angle_o = 16'(qte_pkg::HalfTurnCdeg);
    end else if (rs < -qte_pkg::HalfTurnCdeg) begin
      angle_o = -16'(qte_pkg::HalfTurnCdeg);
    end else begin
      angle_o = rs[15:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/core/quaternion_to_euler_angles.sv
// Top level: frame filter, nine bit-serial product lanes and two CORDIC units.
// Depends on qte_pkg, qte_ser_mul and qte_cordic.
//
//   channel | direction | handshake              | beat
//   input   | in        | in_valid_i / in_stall_o  | qte_pkg::in_item_t
//   output  | out       | out_valid_o / out_stall_i | qte_pkg::out_item_t
//
// A new frame is multiplied bit-serially in StMul, the matrix terms are formed and
// the lock decision registered in StRot, the two CORDIC units run in StCord and the
// result then moves to the output register. The next beat is taken in the cycle
// after the result is loaded into the output register. A repeated frame is
// dropped in the cycle it is accepted. Reset clears the stored frame number to
// zero. A stalled output register holds its beat; the next item is taken meanwhile,
// but a finished result that finds the register still full waits and stalls the input.
`timescale 1ns / 1ps

module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qte_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qte_pkg::out_item_t out_data_o
);

  localparam int unsigned Q  = qte_pkg::QuatBits;
  localparam int unsigned RW = qte_pkg::RW;
  localparam int unsigned NP = qte_pkg::NumProd;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StRot,
    StCord,
    StDone
  } state_e;

  state_e                          state_q;
  logic [31:0]                     last_frame_q;
  logic [qte_pkg::MulCntW-1:0]     cnt_q;
  logic                            lock_q;
  logic                            out_valid_q;
  qte_pkg::out_item_t              out_data_q;

  logic                            in_acc, new_frame, out_free, out_load;
  qte_pkg::mul_ctrl_t              mul_ctrl;
  qte_pkg::cordic_ctrl_t           cor_ctrl;
  logic signed [Q-1:0]             opa [NP];
  logic signed [Q-1:0]             opb [NP];
  logic signed [qte_pkg::PW-1:0]   prod [NP];
  logic signed [RW-1:0]            r0, r1, r2, r3, r6, r7, r8;
  logic signed [RW-1:0]            roll_y, roll_x;
  logic                            lock_d;
  logic                            roll_done, pitch_done;
  logic signed [15:0]              roll_ang, pitch_ang;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign new_frame  = in_acc && (in_data_i.frame_number != last_frame_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // A finished result moves into the output register once that register is free.
  assign out_load   = ((state_q == StDone) ||
                       ((state_q == StCord) && roll_done && pitch_done)) && out_free;

  // Operand pairs: xx, xy, xz, yy, yz, zz, wx, wy, wz.
  always_comb begin
    opa[0] = in_data_i.quat_x; opb[0] = in_data_i.quat_x;
    opa[1] = in_data_i.quat_x; opb[1] = in_data_i.quat_y;
    opa[2] = in_data_i.quat_x; opb[2] = in_data_i.quat_z;
    opa[3] = in_data_i.quat_y; opb[3] = in_data_i.quat_y;
    opa[4] = in_data_i.quat_y; opb[4] = in_data_i.quat_z;
    opa[5] = in_data_i.quat_z; opb[5] = in_data_i.quat_z;
    opa[6] = in_data_i.quat_w; opb[6] = in_data_i.quat_x;
    opa[7] = in_data_i.quat_w; opb[7] = in_data_i.quat_y;
    opa[8] = in_data_i.quat_w; opb[8] = in_data_i.quat_z;
  end

  // Multiplier lane control.
  always_comb begin
    mul_ctrl.load = new_frame;
    mul_ctrl.step = (state_q == StMul);
    mul_ctrl.last = (cnt_q == qte_pkg::MulCntW'(Q - 1));
  end

  for (genvar g = 0; g < NP; g++) begin : g_lane
    qte_ser_mul u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (mul_ctrl),
      .a_i    (opa[g]),
      .b_i    (opb[g]),
      .prod_o (prod[g])
    );
  end

  // Rotation-matrix terms and the gimbal lock decision.
  always_comb begin
    r0 = qte_pkg::QOne - ((RW'(prod[3]) + RW'(prod[5])) <<< 1);
    r1 = (RW'(prod[1]) - RW'(prod[8])) <<< 1;
    r2 = (RW'(prod[2]) + RW'(prod[7])) <<< 1;
    r3 = (RW'(prod[1]) + RW'(prod[8])) <<< 1;
    r6 = (RW'(prod[2]) - RW'(prod[7])) <<< 1;
    r7 = (RW'(prod[4]) + RW'(prod[6])) <<< 1;
    r8 = qte_pkg::QOne - ((RW'(prod[0]) + RW'(prod[3])) <<< 1);
    lock_d = 1'b1;
    if (r6 >= qte_pkg::QOne) begin
      roll_y = -r1;
      roll_x = -r2;
    end else if (r6 <= -qte_pkg::QOne) begin
      roll_y = r1;
      roll_x = r2;
    end else begin
      roll_y = r7;
      roll_x = r8;
      lock_d = 1'b0;
    end
  end

  assign cor_ctrl.start = (state_q == StRot);

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cor_ctrl),
    .y_i     (roll_y),
    .x_i     (roll_x),
    .done_o  (roll_done),
    .angle_o (roll_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cor_ctrl),
    .y_i     (r3),
    .x_i     (r0),
    .done_o  (pitch_done),
    .angle_o (pitch_ang)
  );

  // Sequencer, frame filter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      last_frame_q <= '0;
      cnt_q        <= '0;
      lock_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (new_frame) begin
            last_frame_q <= in_data_i.frame_number;
            cnt_q        <= '0;
            state_q      <= StMul;
          end
        end
        StMul: begin
          cnt_q <= cnt_q + 1'b1;
          if (mul_ctrl.last) begin
            state_q <= StRot;
          end
        end
        StRot: begin
          lock_q  <= lock_d;
          state_q <= StCord;
        end
        StCord, StDone: begin
          if (out_load) begin
            out_data_q.roll_cdeg   <= roll_ang;
            out_data_q.pitch_cdeg  <= lock_q ? 16'sd0 : pitch_ang;
            out_data_q.gimbal_lock <= lock_q;
            state_q                <= StIdle;
          end else if ((state_q == StDone) || (roll_done && pitch_done)) begin
            state_q <= StDone;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_lock_pitch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gimbal_lock |-> out_data_o.pitch_cdeg == 16'sd0)
    else $error("pitch not zero under gimbal lock");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.roll_cdeg <= 16'sd18000) &&
                    (out_data_o.roll_cdeg >= -16'sd18000))
    else $error("roll outside a half turn");

  a_repeat_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.frame_number == last_frame_q) |=> !in_stall_o)
    else $error("repeated frame started work");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking bench for quaternion_to_euler_angles: random and directed quaternion beats.
// Depends on qte_pkg and the block; predicts roll, pitch and lock with a local CORDIC model.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QB = qte_pkg::QuatBits;
  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qte_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qte_pkg::out_item_t out_data_o;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  qte_pkg::in_item_t pending_beats[$];
  qte_pkg::out_item_t expected_angles[$];
  logic [31:0] seen_frame;
  int errors = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 88;
  longint cycles = 0;

  // Arctangent of 2^-i in 1/256 centidegree.
  function automatic longint angle_step(int i);
    longint t[22] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                      5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1};
    if (i < 22) return t[i];
    return 0;
  endfunction

  // Vectoring CORDIC giving atan2(y, x) in saturated centidegrees.
  function automatic longint atan2_cdeg(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x <<< (32 - (QB - 1));
    y = y <<< (32 - (QB - 1));
    if (x < 0) begin
      z = (y >= 0) ? 18000 * 256 : -18000 * 256;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += angle_step(i);
      end else begin
        x -= dx; y += dy; z -= angle_step(i);
      end
    end
    z = (z + 128) >>> 8;
    if (z > 18000) z = 18000;
    if (z < -18000) z = -18000;
    return z;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> (QB - 1);
  endfunction

  // Predicts the angles of one accepted beat; repeated frames give nothing.
  task automatic predict_angles(qte_pkg::in_item_t b);
    longint qx, qy, qz, qw, one;
    longint r0, r1, r2, r3, r6, r7, r8, roll, pitch;
    qte_pkg::out_item_t o;
    if (b.frame_number == seen_frame) return;
    seen_frame = b.frame_number;
    qx = b.quat_x; qy = b.quat_y; qz = b.quat_z; qw = b.quat_w;
    one = longint'(1) << (QB - 1);
    r0 = one - 2 * (qmul(qy, qy) + qmul(qz, qz));
    r1 = 2 * (qmul(qx, qy) - qmul(qw, qz));
    r2 = 2 * (qmul(qx, qz) + qmul(qw, qy));
    r3 = 2 * (qmul(qx, qy) + qmul(qw, qz));
    r6 = 2 * (qmul(qx, qz) - qmul(qw, qy));
    r7 = 2 * (qmul(qy, qz) + qmul(qw, qx));
    r8 = one - 2 * (qmul(qx, qx) + qmul(qy, qy));
    o.gimbal_lock = 1'b1;
    pitch = 0;
    if (r6 >= one) roll = atan2_cdeg(-r1, -r2);
    else if (r6 <= -one) roll = atan2_cdeg(r1, r2);
    else begin
      o.gimbal_lock = 1'b0;
      roll = atan2_cdeg(r7, r8);
      pitch = atan2_cdeg(r3, r0);
    end
    o.roll_cdeg = 16'(roll);
    o.pitch_cdeg = 16'(pitch);
    expected_angles.push_back(o);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: a new beat is presented at the falling edge once the last one has gone; out_stall_i is random.
  logic accepted;
  always @(posedge clk_i) begin
    accepted <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) predict_angles(in_data_i);
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compares every delivered beat with the oldest prediction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected beat, roll", out_data_o.roll_cdeg, 0);
      end else begin
        qte_pkg::out_item_t w;
        w = expected_angles.pop_front();
        if (out_data_o.roll_cdeg !== w.roll_cdeg)
          report_mismatch("roll", out_data_o.roll_cdeg, w.roll_cdeg);
        if (out_data_o.pitch_cdeg !== w.pitch_cdeg)
          report_mismatch("pitch", out_data_o.pitch_cdeg, w.pitch_cdeg);
        if (out_data_o.gimbal_lock !== w.gimbal_lock)
          report_mismatch("lock", out_data_o.gimbal_lock, w.gimbal_lock);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic qte_pkg::in_item_t make_beat(logic [31:0] f, int x, int y, int z, int w);
    qte_pkg::in_item_t b;
    b.frame_number = f;
    b.quat_x = QB'(x); b.quat_y = QB'(y); b.quat_z = QB'(z); b.quat_w = QB'(w);
    return b;
  endfunction

  function automatic int rnd_comp();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  initial begin
    qte_pkg::in_item_t b;
    int a, c, s;
    logic [31:0] f;
    seen_frame = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: frame zero dropped, a repeat, identity, extremes, a gimbal lock, zero vector.
    pending_beats.push_back(make_beat(32'd0, 0, 0, 0, 32767));
    pending_beats.push_back(make_beat(32'd1, 0, 0, 0, 32767));
    pending_beats.push_back(make_beat(32'd1, 100, 200, 300, 400));
    pending_beats.push_back(make_beat(32'hFFFFFFFF, 0, 0, 0, -32768));
    pending_beats.push_back(make_beat(32'd2, -32768, -32768, -32768, -32768));
    pending_beats.push_back(make_beat(32'd3, 32767, 32767, 32767, 32767));
    pending_beats.push_back(make_beat(32'd4, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(32'd5, 0, 23170, 0, -23170));
    pending_beats.push_back(make_beat(32'd6, 0, 23170, 0, 23170));
    pending_beats.push_back(make_beat(32'd7, 23170, 0, 23170, 0));
    pending_beats.push_back(make_beat(32'd8, 16384, -16384, 16384, -16384));
    pending_beats.push_back(make_beat(32'd9, 32767, 0, 0, 0));
    pending_beats.push_back(make_beat(32'd10, 0, 32767, 0, 0));
    pending_beats.push_back(make_beat(32'd11, 0, 0, 32767, 0));
    pending_beats.push_back(make_beat(32'd12, -32768, 0, 0, 0));
    pending_beats.push_back(make_beat(32'd13, 0, -32768, 32767, 0));
    pending_beats.push_back(make_beat(32'd13, 0, 0, 0, 0));
    f = 32'd100;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 88; recv_idle_pct = 30; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int n = 0; n < 380; n++) begin
        s = $urandom_range(9);
        if (s == 0) b = make_beat(f, rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
        else if (s == 1) begin
          // Near gimbal lock: z = +-a, y = -z, x and w +-a with random signs.
          a = $urandom_range(23200, 23100);
          c = $urandom_range(1) ? a : -a;
          b = make_beat(f, $urandom_range(1) ? c : -c, -c, c, $urandom_range(1) ? c : -c);
        end else begin
          // Roughly unit quaternion with random signs.
          a = $urandom_range(32767);
          c = $urandom_range(32767 - a / 2);
          b = make_beat(f, $urandom_range(1) ? a / 2 : -a / 2,
                        $urandom_range(1) ? c / 2 : -c / 2,
                        rnd_comp() / 4, $urandom_range(1) ? 32767 - a / 2 : a / 2 - 32767);
        end
        if ($urandom_range(9) == 0) b.frame_number = f - 1;
        else begin f = $urandom_range(3) == 0 ? $urandom() : f + 1; b.frame_number = f; end
        pending_beats.push_back(b);
      end
      wait (pending_beats.size() == 0 && !in_valid_i);
      wait (expected_angles.size() == 0);
      repeat (LATENCY) @(posedge clk_i);
    end
    wait (expected_angles.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: quaternion_to_euler_angles.f
rtl/core/qte_pkg.sv
rtl/core/qte_ser_mul.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_angles.sv
dv/testbench.sv
